FILE: hw/rtl/hsl_pkg.sv
// Shared constants and types for the HSL to RGB converter.
package hsl_pkg;

   // Hue scale: sixteenths of a degree.
   localparam int HUE_W      = 13;
   localparam int HUE_FULL   = 5760;
   localparam int HUE_SECTOR = 960;
   localparam int HUE_PAIR   = 1920;
   localparam int OFFSET_W   = 10;

   // Saturation / lightness register fields.
   localparam int CFG_W       = 8;
   localparam int CFG_MAX     = 255;
   localparam int AS_W        = 2 * CFG_W;
   localparam int LIGHT_SCALE = 510;     // 2 * 255
   localparam int DIFF_W      = 17;      // holds 510 * 255

   // Internal values are in units of 1 / (2 * 255 * 255 * 960).
   localparam longint UNIT_DEN   = 64'd124848000;
   localparam int     UNIT_W     = 27;
   localparam int     FRAC_SHIFT = 27;   // reciprocal scale, 2^27 > UNIT_DEN
   localparam int     REM_W      = 28;   // remainder below 2 * UNIT_DEN

   // Register map.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_SATURATION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIGHTNESS  = 2'd1;

   // 60-degree hue sectors; bit 0 set means a falling secondary ramp.
   typedef enum logic [2:0] {
      SECT_RED     = 3'd0,
      SECT_YELLOW  = 3'd1,
      SECT_GREEN   = 3'd2,
      SECT_CYAN    = 3'd3,
      SECT_BLUE    = 3'd4,
      SECT_MAGENTA = 3'd5
   } sector_type;

   localparam int NUM_CHAN = 3;

endpackage

FILE: hw/rtl/hsl_to_rgb_converter.sv
// HSL to RGB converter: six-stage pipeline, hue per request, S and L from registers.
// Results: a request taken at a clock edge is registered through every stage and shows its
//   result on the rsp_ ports, with rsp_strobe high for one cycle.
// Throughput: one request per clock; busy never rises since the pipeline cannot stall.
// Reset (synchronous, active high) drops all requests in flight and loads the
//   registers with saturation 204 and lightness 128.
module hsl_to_rgb_converter
   import hsl_pkg::*;
#(
   parameter int COLOR_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   start,
   output logic                   busy,
   input  logic [HUE_W-1:0]       req_hue,
   // result channel
   output logic                   rsp_strobe,
   output logic [COLOR_BITS-1:0]  rsp_red,
   output logic [COLOR_BITS-1:0]  rsp_green,
   output logic [COLOR_BITS-1:0]  rsp_blue,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Channel full scale and the scaled reciprocal of the unit denominator.
   // The estimate floor(v * RECIP / 2^27) is the exact quotient or one below,
   // since v never exceeds UNIT_DEN < 2^27; stage six adds the missing one.
   localparam int                      RECIP_W  = COLOR_BITS + 1;
   localparam longint                  CM_LONG  = (64'd1 << COLOR_BITS) - 64'd1;
   localparam logic [COLOR_BITS-1:0]   CHAN_MAX = '1;
   localparam logic [RECIP_W-1:0]      RECIP    =
      RECIP_W'((CM_LONG << FRAC_SHIFT) / UNIT_DEN);
   localparam logic [UNIT_W-1:0]       DEN_U    = UNIT_W'(UNIT_DEN);
   localparam logic [REM_W-1:0]        DEN_R    = REM_W'(UNIT_DEN);

   // ---------------------------------------------------------------------
   // Configuration registers. Writes must come only while nothing is in
   // flight; the block does not enforce it. Stages 1-2 read them directly.
   // ---------------------------------------------------------------------
   logic [CFG_W-1:0] saturation_ff;
   logic [CFG_W-1:0] lightness_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         saturation_ff <= CFG_W'(204);
         lightness_ff  <= CFG_W'(128);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SATURATION: saturation_ff <= csr_data;
            CSR_LIGHTNESS:  lightness_ff  <= csr_data;
            default: ;     // unmapped index: write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: fold hue, find sector and offset inside it; A = 255-|2L-255|,
   // AS = A * S.
   // ---------------------------------------------------------------------
   logic                  valid1_ff;
   sector_type            sector1_ff, sector1_in;
   logic [OFFSET_W-1:0]   offset1_ff, offset1_in;
   logic [AS_W-1:0]       as1_ff, as1_in;

   logic [HUE_W-1:0]      hue_fold;
   logic [CFG_W:0]        two_l;
   logic [CFG_W-1:0]      dev;
   logic [CFG_W-1:0]      chroma_a;

   always_comb begin
      hue_fold = (req_hue >= HUE_W'(HUE_FULL)) ? req_hue - HUE_W'(HUE_FULL) : req_hue;

      // exact sector boundary belongs to the higher sector
      priority if (hue_fold >= HUE_W'(5 * HUE_SECTOR)) begin
         sector1_in = SECT_MAGENTA;
         offset1_in = OFFSET_W'(hue_fold - HUE_W'(5 * HUE_SECTOR));
      end else if (hue_fold >= HUE_W'(4 * HUE_SECTOR)) begin
         sector1_in = SECT_BLUE;
         offset1_in = OFFSET_W'(hue_fold - HUE_W'(4 * HUE_SECTOR));
      end else if (hue_fold >= HUE_W'(3 * HUE_SECTOR)) begin
         sector1_in = SECT_CYAN;
         offset1_in = OFFSET_W'(hue_fold - HUE_W'(3 * HUE_SECTOR));
      end else if (hue_fold >= HUE_W'(2 * HUE_SECTOR)) begin
         sector1_in = SECT_GREEN;
         offset1_in = OFFSET_W'(hue_fold - HUE_W'(2 * HUE_SECTOR));
      end else if (hue_fold >= HUE_W'(HUE_SECTOR)) begin
         sector1_in = SECT_YELLOW;
         offset1_in = OFFSET_W'(hue_fold - HUE_W'(HUE_SECTOR));
      end else begin
         sector1_in = SECT_RED;
         offset1_in = OFFSET_W'(hue_fold);
      end

      two_l    = {lightness_ff, 1'b0};
      dev      = (two_l >= (CFG_W+1)'(CFG_MAX)) ? CFG_W'(two_l - (CFG_W+1)'(CFG_MAX))
                                                : CFG_W'((CFG_W+1)'(CFG_MAX) - two_l);
      chroma_a = CFG_W'(CFG_MAX) - dev;
      as1_in   = AS_W'(chroma_a) * AS_W'(saturation_ff);
   end

   // ---------------------------------------------------------------------
   // Stage 2: ramp weight w, then c = AS*1920, x = 2*AS*w,
   // m = 960*(510L - AS), all in common units.
   // ---------------------------------------------------------------------
   logic                valid2_ff;
   sector_type          sector2_ff;
   logic [UNIT_W-1:0]   cu2_ff, cu2_in;
   logic [UNIT_W-1:0]   xu2_ff, xu2_in;
   logic [UNIT_W-1:0]   mu2_ff, mu2_in;

   logic [OFFSET_W-1:0] ramp_w;
   logic [DIFF_W-1:0]   m_diff;

   always_comb begin
      // rising ramp in even sectors, falling in odd ones
      ramp_w = sector1_ff[0] ? OFFSET_W'(HUE_SECTOR) - offset1_ff : offset1_ff;
      xu2_in = UNIT_W'({as1_ff, 1'b0}) * UNIT_W'(ramp_w);
      cu2_in = UNIT_W'(as1_ff) * UNIT_W'(HUE_PAIR);
      m_diff = DIFF_W'(lightness_ff) * DIFF_W'(LIGHT_SCALE) - DIFF_W'(as1_ff);
      mu2_in = UNIT_W'(m_diff) * UNIT_W'(HUE_SECTOR);
   end

   // ---------------------------------------------------------------------
   // Stage 3: add the offset and route components by sector.
   // Lane 0 red, 1 green, 2 blue.
   // ---------------------------------------------------------------------
   logic                              valid3_ff;
   logic [NUM_CHAN-1:0][UNIT_W-1:0]   v3_ff, v3_in;

   logic [UNIT_W-1:0] vc, vx;

   always_comb begin
      vc = cu2_ff + mu2_ff;
      vx = xu2_ff + mu2_ff;
      unique case (sector2_ff)
         SECT_RED:     v3_in = {mu2_ff, vx, vc};
         SECT_YELLOW:  v3_in = {mu2_ff, vc, vx};
         SECT_GREEN:   v3_in = {vx, vc, mu2_ff};
         SECT_CYAN:    v3_in = {vc, vx, mu2_ff};
         SECT_BLUE:    v3_in = {vc, mu2_ff, vx};
         default:      v3_in = {vx, mu2_ff, vc};   // magenta
      endcase
   end

   // ---------------------------------------------------------------------
   // Stage 4: quotient estimate q0 = floor(v * RECIP / 2^27).
   // Stage 5: low remainder bits of v*CM and q0*D.
   // Stage 6: correct by one, clamp, drive the outputs.
   // ---------------------------------------------------------------------
   logic                                valid4_ff;
   logic [NUM_CHAN-1:0][UNIT_W-1:0]     v4_ff;
   logic [NUM_CHAN-1:0][COLOR_BITS-1:0] q4_ff, q4_in;

   logic                                valid5_ff;
   logic [NUM_CHAN-1:0][COLOR_BITS-1:0] q5_ff;
   logic [NUM_CHAN-1:0][REM_W-1:0]      pv5_ff, pv5_in;
   logic [NUM_CHAN-1:0][REM_W-1:0]      pq5_ff, pq5_in;

   logic [NUM_CHAN-1:0][COLOR_BITS-1:0] chan_in;

   logic [UNIT_W+RECIP_W-1:0]     est_prod   [NUM_CHAN];
   logic [UNIT_W+COLOR_BITS-1:0]  vcm_prod   [NUM_CHAN];
   logic [UNIT_W+COLOR_BITS-1:0]  qd_prod    [NUM_CHAN];
   logic [REM_W-1:0]              rem        [NUM_CHAN];
   logic [COLOR_BITS:0]           q_fix      [NUM_CHAN];

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         est_prod[i] = (UNIT_W+RECIP_W)'(v3_ff[i]) * (UNIT_W+RECIP_W)'(RECIP);
         q4_in[i]    = est_prod[i][FRAC_SHIFT +: COLOR_BITS];

         vcm_prod[i] = (UNIT_W+COLOR_BITS)'(v4_ff[i]) * (UNIT_W+COLOR_BITS)'(CHAN_MAX);
         qd_prod[i]  = (UNIT_W+COLOR_BITS)'(q4_ff[i]) * (UNIT_W+COLOR_BITS)'(DEN_U);
         pv5_in[i]   = vcm_prod[i][REM_W-1:0];
         pq5_in[i]   = qd_prod[i][REM_W-1:0];

         // true remainder lies in [0, 2D), so the low bits are enough
         rem[i]   = pv5_ff[i] - pq5_ff[i];
         q_fix[i] = {1'b0, q5_ff[i]} + (COLOR_BITS+1)'(rem[i] >= DEN_R);
         chan_in[i] = (q_fix[i] > {1'b0, CHAN_MAX}) ? CHAN_MAX : q_fix[i][COLOR_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline registers. Only the valid bits are reset.
   // ---------------------------------------------------------------------
   logic                  strobe_ff;
   logic [COLOR_BITS-1:0] red_ff, green_ff, blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         valid1_ff <= start && !busy;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
         strobe_ff <= valid5_ff;
      end

      sector1_ff <= sector1_in;
      offset1_ff <= offset1_in;
      as1_ff     <= as1_in;

      sector2_ff <= sector1_ff;
      cu2_ff     <= cu2_in;
      xu2_ff     <= xu2_in;
      mu2_ff     <= mu2_in;

      v3_ff      <= v3_in;

      v4_ff      <= v3_ff;
      q4_ff      <= q4_in;

      q5_ff      <= q4_ff;
      pv5_ff     <= pv5_in;
      pq5_ff     <= pq5_in;

      red_ff     <= chan_in[0];
      green_ff   <= chan_in[1];
      blue_ff    <= chan_in[2];
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_red    = red_ff;
   assign rsp_green  = green_ff;
   assign rsp_blue   = blue_ff;

endmodule

FILE: tb/tb_hsl_to_rgb_converter.sv
// Self-checking testbench for the HSL to RGB converter: directed probes, then random hues.
module tb_hsl_to_rgb_converter
   import hsl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLOR_BITS = 8;
   localparam longint unsigned CHAN_MAX = (64'd1 << COLOR_BITS) - 64'd1;

   // Indexes past the two registers; writes there must leave the state alone.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;

   localparam int SAT_AT_RESET   = 204;
   localparam int LIT_AT_RESET   = 128;
   localparam int RESET_CYCLES   = 5;
   localparam int PIPE_LATENCY   = 6;     // stage count of the block
   localparam int STALL_LIMIT    = 1000;  // cycles with no handshake of any kind
   localparam int NUM_SEGMENTS   = 9;
   localparam int SEGMENT_ITEMS  = 200;

   typedef struct packed {
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } rgb_type;

   // One directed probe: the register setting, the hue, and a typed-in
   // color where it is obvious (gray, black, white, pure sector corners).
   typedef struct packed {
      logic [CFG_W-1:0] sat;
      logic [CFG_W-1:0] lit;
      logic [HUE_W-1:0] hue;
      logic             known;
      rgb_type          rgb;
   } probe_row_type;

   localparam int NUM_PROBES = 23;

   probe_row_type probes [NUM_PROBES] = '{
      // reset setting: sector edges and out-of-range hues that fold once
      '{8'd204, 8'd128, 13'd0,    1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd204, 8'd128, 13'd959,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd204, 8'd128, 13'd960,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd204, 8'd128, 13'd5759, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd204, 8'd128, 13'd5760, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd204, 8'd128, 13'd8191, 1'b0, '{8'd0,   8'd0,   8'd0}},
      // zero saturation gives gray at the lightness value
      '{8'd0,   8'd77,  13'd1234, 1'b1, '{8'd77,  8'd77,  8'd77}},
      '{8'd0,   8'd200, 13'd4000, 1'b1, '{8'd200, 8'd200, 8'd200}},
      // lightness extremes: black and white whatever the hue
      '{8'd255, 8'd0,   13'd3000, 1'b1, '{8'd0,   8'd0,   8'd0}},
      '{8'd123, 8'd255, 13'd100,  1'b1, '{8'd255, 8'd255, 8'd255}},
      // full saturation, mid lightness: the six sector starts, then edge and mixed cases
      '{8'd255, 8'd128, 13'd0,    1'b1, '{8'd255, 8'd1,   8'd1}},
      '{8'd255, 8'd128, 13'd960,  1'b1, '{8'd255, 8'd255, 8'd1}},
      '{8'd255, 8'd128, 13'd1920, 1'b1, '{8'd1,   8'd255, 8'd1}},
      '{8'd255, 8'd128, 13'd2880, 1'b1, '{8'd1,   8'd255, 8'd255}},
      '{8'd255, 8'd128, 13'd3840, 1'b1, '{8'd1,   8'd1,   8'd255}},
      '{8'd255, 8'd128, 13'd4800, 1'b1, '{8'd255, 8'd1,   8'd255}},
      '{8'd255, 8'd128, 13'd5760, 1'b1, '{8'd255, 8'd1,   8'd1}},
      '{8'd255, 8'd128, 13'd1919, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd255, 8'd128, 13'd8191, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd255, 8'd127, 13'd480,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd1,   8'd1,   13'd2222, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{8'd255, 8'd255, 13'd4321, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{8'd0,   8'd0,   13'd7000, 1'b1, '{8'd0,   8'd0,   8'd0}}
   };

   // DUT ports; the inputs are known from time zero
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   start      = 1'b0;
   logic                   busy;
   logic [HUE_W-1:0]       req_hue    = '0;
   logic                   rsp_strobe;
   logic [COLOR_BITS-1:0]  rsp_red;
   logic [COLOR_BITS-1:0]  rsp_green;
   logic [COLOR_BITS-1:0]  rsp_blue;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // testbench copy of the two registers
   logic [CFG_W-1:0] sat_reg = CFG_W'(SAT_AT_RESET);
   logic [CFG_W-1:0] lit_reg = CFG_W'(LIT_AT_RESET);

   rgb_type pending_rgb [$];   // colors still owed by the pipeline, oldest first
   int   fail_count    = 0;
   int   checked_count = 0;
   int   hue_count     = 0;
   int   setting_count = 0;
   int   stall_cycles  = 0;

   hsl_to_rgb_converter #(.COLOR_BITS(COLOR_BITS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_hue    (req_hue),
      .rsp_strobe (rsp_strobe),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Exact fixed-point conversion. All values are in units of
   // 1 / (2 * 255 * 255 * 960), so only the final scaling truncates.
   function automatic logic [COLOR_BITS-1:0] units_to_chan(input longint unsigned units);
      longint unsigned level;
      level = (units * CHAN_MAX) / longint'(UNIT_DEN);
      if (level > CHAN_MAX) level = CHAN_MAX;
      return COLOR_BITS'(level);
   endfunction

   function automatic rgb_type hsl_color(input logic [HUE_W-1:0] hue_in,
                                         input logic [CFG_W-1:0] sat,
                                         input logic [CFG_W-1:0] lit);
      longint unsigned h, two_l, dev, amp_sat, hm, ramp_dist, ramp, c_u, x_u, m_u;
      longint unsigned r_u, g_u, b_u;
      sector_type      sector;
      rgb_type         color;
      h = 64'(hue_in);
      if (h >= HUE_FULL) h -= HUE_FULL;        // one fold covers the 13-bit field
      two_l     = 2 * longint'(lit);
      dev       = (two_l >= CFG_MAX) ? two_l - CFG_MAX : CFG_MAX - two_l;
      amp_sat   = (CFG_MAX - dev) * longint'(sat);
      hm        = h % HUE_PAIR;
      ramp_dist = (hm >= HUE_SECTOR) ? hm - HUE_SECTOR : HUE_SECTOR - hm;
      ramp      = HUE_SECTOR - ramp_dist;
      c_u       = amp_sat * 1920;
      x_u       = amp_sat * 2 * ramp;
      m_u       = longint'(lit) * 489600 - amp_sat * 960;
      sector    = sector_type'(3'(h / HUE_SECTOR));
      unique case (sector)
         SECT_RED: begin
            r_u = c_u; g_u = x_u; b_u = 0;
         end
         SECT_YELLOW: begin
            r_u = x_u; g_u = c_u; b_u = 0;
         end
         SECT_GREEN: begin
            r_u = 0;   g_u = c_u; b_u = x_u;
         end
         SECT_CYAN: begin
            r_u = 0;   g_u = x_u; b_u = c_u;
         end
         SECT_BLUE: begin
            r_u = x_u; g_u = 0;   b_u = c_u;
         end
         default: begin
            r_u = c_u; g_u = 0;   b_u = x_u;
         end
      endcase
      color.red   = units_to_chan(r_u + m_u);
      color.green = units_to_chan(g_u + m_u);
      color.blue  = units_to_chan(b_u + m_u);
      return color;
   endfunction

   task automatic check_chan(input string name, input logic [COLOR_BITS-1:0] want,
                             input logic [COLOR_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Result side: the block cannot be stalled, so every strobe is taken at the
   // edge that ends its cycle and matched against the oldest owed color.
   // Also feeds the watchdog with any handshake seen at this edge.
   always @(posedge clock) begin
      rgb_type want;
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (!reset && rsp_strobe) begin
         if (pending_rgb.size() == 0) begin
            $error("result with no request outstanding: %0d %0d %0d",
                   rsp_red, rsp_green, rsp_blue);
            fail_count++;
         end else begin
            want = pending_rgb.pop_front();
            check_chan("red",   want.red,   rsp_red);
            check_chan("green", want.green, rsp_green);
            check_chan("blue",  want.blue,  rsp_blue);
            checked_count++;
         end
      end
   end

   // Watchdog: nothing moving for too long means a hang.
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("[hsl_to_rgb_converter] ERROR");
      $finish;
   end

   // Register write; valid stays low for one cycle afterwards so that a
   // following write never lowers and raises it in the same step.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SATURATION) sat_reg = val;
      else if (idx == CSR_LIGHTNESS) lit_reg = val;
      @(posedge clock);
   endtask

   // Stop sending and wait until every owed color has come back.
   task automatic drain_pipe();
      start <= 1'b0;
      while (pending_rgb.size() != 0) @(posedge clock);
   endtask

   // Registers change only with the pipeline empty.
   task automatic apply_setting(input logic [CFG_W-1:0] sat, input logic [CFG_W-1:0] lit);
      drain_pipe();
      write_reg(CSR_SATURATION, sat);
      write_reg(CSR_LIGHTNESS, lit);
      setting_count++;
   endtask

   // Offer one hue request and hold it until the block takes it. The owed
   // color is either typed in by the caller or worked out here.
   task automatic send_hue(input logic [HUE_W-1:0] hue, input logic known,
                           input rgb_type typed);
      start   <= 1'b1;
      req_hue <= hue;
      do @(posedge clock); while (busy);
      pending_rgb.push_back(known ? typed : hsl_color(hue, sat_reg, lit_reg));
      hue_count++;
   endtask

   // Mostly in-range hues, a share right at sector edges, and some above
   // 5759 that exercise the fold.
   function automatic logic [HUE_W-1:0] pick_hue();
      int roll;
      int h;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         h = $urandom_range(0, HUE_FULL - 1);
      else if (roll < 85)
         h = $urandom_range(0, 5) * HUE_SECTOR + $urandom_range(0, 2) - 1;
      else
         h = $urandom_range(HUE_FULL, (1 << HUE_W) - 1);
      return HUE_W'(h);
   endfunction

   initial begin
      int   idle_pct;
      logic [CFG_W-1:0] seg_sat;
      logic [CFG_W-1:0] seg_lit;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Writes to the unused indexes must not disturb the reset setting,
      // which the first probes rely on.
      write_reg(CSR_SPARE_LO, 8'hFF);
      write_reg(CSR_SPARE_HI, 8'h00);

      // Directed probes, back to back within each register setting.
      for (int i = 0; i < NUM_PROBES; i++) begin
         if (probes[i].sat != sat_reg || probes[i].lit != lit_reg)
            apply_setting(probes[i].sat, probes[i].lit);
         send_hue(probes[i].hue, probes[i].known, probes[i].rgb);
      end

      // Random part: one register setting per segment, extremes first.
      // Segments 0-2 idle the sender about 17 percent of the time, 3-5 about
      // 77 percent, then never.
      // Each segment boundary drains the pipeline before the next write.
      for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
         unique case (seg)
            0: begin seg_sat = 8'd255; seg_lit = 8'd255; end
            1: begin seg_sat = 8'd0;   seg_lit = 8'd0;   end
            2: begin seg_sat = 8'd255; seg_lit = 8'd0;   end
            3: begin seg_sat = 8'd0;   seg_lit = 8'd255; end
            4: begin seg_sat = 8'd255; seg_lit = 8'd128; end
            default: begin
               seg_sat = CFG_W'($urandom_range(0, CFG_MAX));
               seg_lit = CFG_W'($urandom_range(0, CFG_MAX));
            end
         endcase
         apply_setting(seg_sat, seg_lit);
         idle_pct = (seg < 3) ? 17 : (seg < 6) ? 77 : 0;
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            // each cycle idles with the segment's odds; gaps of any length
            // land on every stage of the pipe
            while ($urandom_range(0, 99) < idle_pct) begin
               start <= 1'b0;
               @(posedge clock);
            end
            send_hue(pick_hue(), 1'b0, '0);
         end
      end

      drain_pipe();
      // wait past the pipeline depth to catch any stray strobe
      repeat (PIPE_LATENCY + 4) @(posedge clock);

      $display("Sent %0d hues over %0d register settings (incl. extremes and folded hues);",
               hue_count, setting_count);
      $display("%0d colors compared, %0d still owed, %0d mismatches.",
               checked_count, pending_rgb.size(), fail_count);
      if (fail_count == 0 && pending_rgb.size() == 0)
         $display("[hsl_to_rgb_converter] OK");
      else
         $display("[hsl_to_rgb_converter] ERROR");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/hsl_pkg.sv
hw/rtl/hsl_to_rgb_converter.sv
tb/tb_hsl_to_rgb_converter.sv
